// File: hdl/bounded_back_forward_history_macros.svh
// Assertion macros for the bounded back/forward history block.
// Used by the port-level checker; no other dependencies.
`ifndef BOUNDED_BACK_FORWARD_HISTORY_MACROS_SVH
`define BOUNDED_BACK_FORWARD_HISTORY_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the reset is high.
`define BBFH_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion on clk, disabled during rst.
`define BBFH_ASSERT(label, prop, msg) \
  `BBFH_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// File: hdl/bbfh_pkg.sv
// Shared constants, types and helper functions for the navigation history.
// Used by the key store, the sequencer and the top level; depends on nothing.
`timescale 1ns / 1ps

package bbfh_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int FRESH_W = $clog2(DEPTH + 2);
  localparam int SUM_W   = FRESH_W + 1;

  localparam int PORT_KEY_W   = 32;
  localparam int PORT_COUNT_W = 5;
  localparam int MAX_W        = 5;
  localparam int CMD_W        = 2;
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_VISIT   = 2'd0,
    CMD_BACK    = 2'd1,
    CMD_FORWARD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOME_KEY    = 1'b0,
    REG_MAX_ENTRIES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PORT_KEY_W-1:0] home_key;
    logic [MAX_W-1:0]      max_entries;
  } cfg_t;

  typedef struct packed {
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_slot;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_slot;
    logic [KEY_BITS-1:0] wr_key;
  } mem_req_t;

  // Ring slot at a given offset (at most DEPTH) from a base slot.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [FRESH_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

  // Entry limit with zero taken as one and large values clipped to DEPTH.
  function automatic logic [FRESH_W-1:0] limit_of(input logic [MAX_W-1:0] max_entries);
    logic [FRESH_W-1:0] lim;
    if (max_entries == '0) begin
      lim = FRESH_W'(1);
    end else if (int'(max_entries) > DEPTH) begin
      lim = FRESH_W'(DEPTH);
    end else begin
      lim = FRESH_W'(max_entries);
    end
    return lim;
  endfunction

endpackage

// File: hdl/bbfh_store.sv
// Key store of the history ring: one write port, one registered read port.
// Depends on bbfh_pkg for the depth, key width and request struct.
`timescale 1ns / 1ps

module bbfh_store (
  input  logic                          clk,
  input  bbfh_pkg::mem_req_t            req,
  output logic [bbfh_pkg::KEY_BITS-1:0] rd_key
);

  logic [bbfh_pkg::KEY_BITS-1:0] mem [bbfh_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot] <= req.wr_key;
    end
    if (req.rd_en) begin
      rd_key <= mem[req.rd_slot];
    end
  end

endmodule

// File: hdl/bbfh_ctrl.sv
// Command sequencer: reads the current entry, compares, writes back and
// moves the ring pointers. Depends on bbfh_pkg; drives the key store.
`timescale 1ns / 1ps

module bbfh_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  bbfh_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bbfh_pkg::CMD_W-1:0]        in_cmd,
  input  logic [bbfh_pkg::PORT_KEY_W-1:0]   in_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bbfh_pkg::PORT_KEY_W-1:0]   out_key,
  output logic [bbfh_pkg::PORT_COUNT_W-1:0] out_count,
  output bbfh_pkg::mem_req_t                mem_req,
  input  logic [bbfh_pkg::KEY_BITS-1:0]     rd_key
);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t                           state;
  logic [bbfh_pkg::SLOT_W-1:0]      oldest;
  logic [bbfh_pkg::COUNT_W-1:0]     count;
  logic [bbfh_pkg::SLOT_W-1:0]      cursor;
  logic                             home_pending;
  bbfh_pkg::cmd_t                   cmd_q;
  logic [bbfh_pkg::KEY_BITS-1:0]    key_q;
  logic [bbfh_pkg::SLOT_W-1:0]      cur_slot;
  logic [bbfh_pkg::SLOT_W-1:0]      next_slot;

  logic                             accept;
  bbfh_pkg::cmd_t                   cmd_in;
  logic [bbfh_pkg::SLOT_W-1:0]      cursor_next;
  logic [bbfh_pkg::SLOT_W-1:0]      rd_slot;
  logic [bbfh_pkg::SLOT_W-1:0]      append_slot;
  logic [bbfh_pkg::KEY_BITS-1:0]    entry_key;
  logic                             out_free;
  logic                             changed;
  logic [bbfh_pkg::FRESH_W-1:0]     fresh;
  logic [bbfh_pkg::FRESH_W-1:0]     limit;
  logic                             evict;
  logic [bbfh_pkg::FRESH_W-1:0]     kept;
  logic [bbfh_pkg::SLOT_W-1:0]      oldest_next;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign cmd_in   = bbfh_pkg::cmd_t'(in_cmd);

  // Back and forward move the cursor when the item is taken, so the read
  // already fetches the entry that becomes current.
  always_comb begin
    cursor_next = cursor;
    unique case (cmd_in)
      bbfh_pkg::CMD_BACK: begin
        if (cursor != '0) begin
          cursor_next = cursor - 1'b1;
        end
      end
      bbfh_pkg::CMD_FORWARD: begin
        if (bbfh_pkg::COUNT_W'(cursor) + 1'b1 < count) begin
          cursor_next = cursor + 1'b1;
        end
      end
      bbfh_pkg::CMD_VISIT,
      bbfh_pkg::CMD_NONE: begin
        cursor_next = cursor;
      end
    endcase
  end

  assign rd_slot     = bbfh_pkg::slot_add(oldest, bbfh_pkg::FRESH_W'(cursor_next));
  assign append_slot = bbfh_pkg::slot_add(oldest, bbfh_pkg::FRESH_W'(cursor) + 1'b1);

  // Slot zero reads the live home key until a visit first writes it.
  assign entry_key = (cur_slot == '0 && home_pending) ?
                     bbfh_pkg::KEY_BITS'(cfg.home_key) : rd_key;
  assign out_free  = !out_valid || out_ready;
  assign changed   = (cmd_q == bbfh_pkg::CMD_VISIT) && (entry_key != key_q);

  assign fresh       = bbfh_pkg::FRESH_W'(cursor) + bbfh_pkg::FRESH_W'(2);
  assign limit       = bbfh_pkg::limit_of(cfg.max_entries);
  assign evict       = fresh > limit;
  assign kept        = evict ? limit : fresh;
  assign oldest_next = evict ? bbfh_pkg::slot_add(oldest, fresh - limit) : oldest;

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.rd_slot = rd_slot;
    mem_req.wr_en   = (state == ST_READ) && out_free && changed;
    mem_req.wr_slot = next_slot;
    mem_req.wr_key  = key_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      oldest       <= '0;
      count        <= bbfh_pkg::COUNT_W'(1);
      cursor       <= '0;
      home_pending <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      // A new result loads the output register; otherwise a transfer empties it.
      if (state == ST_READ && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q     <= cmd_in;
            key_q     <= bbfh_pkg::KEY_BITS'(in_key);
            cur_slot  <= rd_slot;
            next_slot <= append_slot;
            cursor    <= cursor_next;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          // The read data stays put here until the output register frees up.
          if (out_free) begin
            if (changed) begin
              count     <= bbfh_pkg::COUNT_W'(kept);
              cursor    <= bbfh_pkg::SLOT_W'(kept - 1'b1);
              oldest    <= oldest_next;
              if (next_slot == '0) begin
                home_pending <= 1'b0;
              end
              out_key   <= bbfh_pkg::PORT_KEY_W'(key_q);
              out_count <= bbfh_pkg::PORT_COUNT_W'(kept);
            end else begin
              out_key   <= bbfh_pkg::PORT_KEY_W'(entry_key);
              out_count <= bbfh_pkg::PORT_COUNT_W'(count);
            end
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/bounded_back_forward_history.sv
// Bounded back/forward navigation history, top level.
// Holds the configuration registers; depends on bbfh_pkg, bbfh_ctrl and bbfh_store.
//
// Use: commands enter on the s_ stream (s_tuser = command: 0 visit, 1 back,
// 2 forward; s_tdata = page key). Each command gives one result on the m_
// stream: the current key after the command and the number of entries held.
// Configuration writes come over the cfg_ channel (index 0 home key, index 1
// entry limit) and are taken in every cycle; write them only while idle.
// A taken command first reads the key store's registered port; the write-back
// step then loads the result into the output register. One command is in work at
// a time; a finished result waits in the output register while the next
// command is taken. If the receiver stalls with a result still waiting, the
// following command holds in its write-back step until that result moves.
// After reset the history holds one entry, the home key, with the cursor on
// it; the limit is 16 and the home key is zero until written.
`timescale 1ns / 1ps

module bounded_back_forward_history (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // [31:0] page_key
  input  logic [1:0]                          s_tuser,   // [1:0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,   // [31:0] current_key,
                                                         // [36:32] history_count
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bbfh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  bbfh_pkg::cfg_t                         cfg;
  bbfh_pkg::mem_req_t                     mem_req;
  logic [bbfh_pkg::KEY_BITS-1:0]          rd_key;
  logic [bbfh_pkg::PORT_KEY_W-1:0]        out_key;
  logic [bbfh_pkg::PORT_COUNT_W-1:0]      out_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_key    <= '0;
      cfg.max_entries <= bbfh_pkg::MAX_W'(bbfh_pkg::DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (bbfh_pkg::cfg_reg_t'(cfg_index))
        bbfh_pkg::REG_HOME_KEY:    cfg.home_key    <= cfg_data;
        bbfh_pkg::REG_MAX_ENTRIES: cfg.max_entries <= cfg_data[bbfh_pkg::MAX_W-1:0];
      endcase
    end
  end

  bbfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_key    (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_key   (out_key),
    .out_count (out_count),
    .mem_req   (mem_req),
    .rd_key    (rd_key)
  );

  bbfh_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_key (rd_key)
  );

  assign m_tdata = {3'b000, out_count, out_key};

endmodule

// File: hdl/bbfh_checker.sv
// Port-level checker for the navigation history, bound to the top level.
// Depends on bounded_back_forward_history_macros.svh.
`timescale 1ns / 1ps
`include "bounded_back_forward_history_macros.svh"

module bbfh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `BBFH_ASSERT(a_count_range, m_tvalid |-> (m_tdata[36:32] != 5'd0 && m_tdata[36:32] <= 5'd16), "history_count outside 1..16")
  `BBFH_ASSERT(a_one_in_work, (s_tvalid && s_tready) |=> !s_tready, "second command taken while one is in work")
  `BBFH_ASSERT(a_result_after_cmd, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result appeared without a command two cycles earlier")
  `BBFH_ASSERT(a_result_held, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result dropped or changed")

endmodule

bind bounded_back_forward_history bbfh_checker u_bbfh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/bounded_back_forward_history_tb.sv
// Self-checking testbench for the bounded back/forward navigation history.
// Depends on bbfh_pkg and bounded_back_forward_history. It runs directed and random
// command streams against a local prediction of the history ring.
`timescale 1ns / 1ps

module bounded_back_forward_history_tb;
  import bbfh_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_CMDS    = 288;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
    logic        drain;
  } nav_cmd_t;

  typedef struct packed {
    logic [31:0]             key;
    logic [PORT_COUNT_W-1:0] count;
  } page_view_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // Commands waiting to be sent and page views the block still owes.
  nav_cmd_t   nav_queue[$];
  page_view_t page_views_due[$];

  int cmds_sent;
  int cmds_taken;
  int cfg_writes_taken;
  int mismatches;
  int cycle_count;
  int send_idle;
  int recv_idle;

  // Predicted history ring and the configuration it works under.
  logic [31:0]        ring_keys [DEPTH];
  logic [SLOT_W-1:0]  ring_oldest;
  logic [COUNT_W-1:0] ring_count;
  logic [SLOT_W-1:0]  ring_cursor;
  logic               home_unwritten;
  logic [31:0]        cfg_home;
  logic [MAX_W-1:0]   cfg_max;

  logic [31:0] key_pool [4];
  logic [31:0] last_visit_key;

  bounded_back_forward_history i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] key_at(input int offset);
    logic [SLOT_W-1:0] slot;
    slot = ring_oldest + SLOT_W'(offset);
    if (slot == '0 && home_unwritten) begin
      return cfg_home;
    end
    return ring_keys[slot];
  endfunction

  task automatic step_history(input cmd_t cmd, input logic [31:0] key,
                              output page_view_t view);
    int fresh;
    int lim;
    logic [SLOT_W-1:0] slot;
    case (cmd)
      CMD_VISIT: begin
        if (key_at(int'(ring_cursor)) != key) begin
          fresh = int'(ring_cursor) + 2;
          if (cfg_max == '0) begin
            lim = 1;
          end else if (int'(cfg_max) > DEPTH) begin
            lim = DEPTH;
          end else begin
            lim = int'(cfg_max);
          end
          slot = ring_oldest + SLOT_W'(int'(ring_cursor) + 1);
          ring_keys[slot] = key;
          if (slot == '0) begin
            home_unwritten = 1'b0;
          end
          // Appending past the limit drops as many of the oldest entries as needed.
          if (fresh > lim) begin
            ring_oldest = ring_oldest + SLOT_W'(fresh - lim);
            fresh = lim;
          end
          ring_count  = COUNT_W'(fresh);
          ring_cursor = SLOT_W'(fresh - 1);
        end
      end
      CMD_BACK: begin
        if (ring_cursor != '0) begin
          ring_cursor = ring_cursor - 1'b1;
        end
      end
      CMD_FORWARD: begin
        if (int'(ring_cursor) + 1 < int'(ring_count)) begin
          ring_cursor = ring_cursor + 1'b1;
        end
      end
      default: begin
      end
    endcase
    view.key   = key_at(int'(ring_cursor));
    view.count = PORT_COUNT_W'(ring_count);
  endtask

  // Monitor: checks results, predicts accepted commands, tracks register writes.
  always @(posedge clk) begin
    page_view_t want;
    page_view_t view;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL bounded_back_forward_history");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (page_views_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none due, got key %h count %0d",
                   $time, m_tdata[31:0], m_tdata[36:32]);
        end else begin
          want = page_views_due.pop_front();
          if (m_tdata[31:0] !== want.key) begin
            mismatches++;
            $display("%0t: current_key expected %h got %h", $time, want.key, m_tdata[31:0]);
          end
          if (m_tdata[36:32] !== want.count) begin
            mismatches++;
            $display("%0t: history_count expected %0d got %0d",
                     $time, want.count, m_tdata[36:32]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        step_history(cmd_t'(s_tuser), s_tdata, view);
        page_views_due.insert(page_views_due.size(), view);
        cmds_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOME_KEY:    cfg_home = cfg_data;
          REG_MAX_ENTRIES: cfg_max  = cfg_data[MAX_W-1:0];
          default: begin
          end
        endcase
        cfg_writes_taken++;
      end
    end
  end

  // Driver: presents queued commands and randomizes back-pressure.
  always @(negedge clk) begin
    nav_cmd_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      // A command still waiting for its transfer holds on the bus.
      if (cmds_taken == cmds_sent) begin
        if (nav_queue.size() != 0 && $urandom_range(99) >= send_idle &&
            !(nav_queue[0].drain && page_views_due.size() != 0)) begin
          item = nav_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.key;
          s_tuser  <= item.cmd;
          cmds_sent++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic add_cmd(input cmd_t cmd, input logic [31:0] key, input logic drain = 1'b0);
    nav_cmd_t item;
    item.cmd   = cmd;
    item.key   = key;
    item.drain = drain;
    nav_queue.insert(nav_queue.size(), item);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    int seen;
    seen = cfg_writes_taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_writes_taken == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (nav_queue.size() != 0 || cmds_taken != cmds_sent || page_views_due.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Random commands lean on visits, with keys from a small pool so that
  // equal visits and revisits happen often.
  function automatic nav_cmd_t random_command();
    nav_cmd_t item;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      item.cmd = CMD_VISIT;
    end else if (pick < 70) begin
      item.cmd = CMD_BACK;
    end else if (pick < 94) begin
      item.cmd = CMD_FORWARD;
    end else begin
      item.cmd = CMD_NONE;
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      item.key = key_pool[$urandom_range(3)];
    end else if (pick < 50) begin
      item.key = last_visit_key;
    end else begin
      item.key = $urandom;
    end
    if (item.cmd == CMD_VISIT) begin
      last_visit_key = item.key;
    end
    item.drain = ($urandom_range(149) == 0);
    return item;
  endfunction

  initial begin
    logic [MAX_W-1:0] phase_max [RANDOM_PHASES];
    logic [31:0] home;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmds_sent = 0;
    cmds_taken = 0;
    cfg_writes_taken = 0;
    mismatches = 0;
    cycle_count = 0;
    send_idle = 37;
    recv_idle = 47;
    ring_oldest    = '0;
    ring_count     = COUNT_W'(1);
    ring_cursor    = '0;
    home_unwritten = 1'b1;
    cfg_home       = '0;
    cfg_max        = MAX_W'(16);
    last_visit_key = '0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Moves at both ends, equal visits, the unused command and truncation.
    write_reg(REG_HOME_KEY, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ENTRIES, 32'd16);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_FORWARD, 32'h0);
    add_cmd(CMD_VISIT, 32'hFFFF_FFFF);
    add_cmd(CMD_VISIT, 32'h0000_0000);
    add_cmd(CMD_VISIT, 32'hFFFF_FFFF);
    add_cmd(CMD_VISIT, 32'hFFFF_FFFF);
    add_cmd(CMD_NONE, 32'hA5A5_A5A5);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_FORWARD, 32'h0);
    add_cmd(CMD_VISIT, 32'h5A5A_5A5A);
    add_cmd(CMD_FORWARD, 32'h0);
    add_cmd(CMD_BACK, 32'h0);
    wait_idle();

    // The home entry follows a rewritten home key while its slot is unwritten;
    // the limit drops below the count and the next append evicts.
    write_reg(REG_HOME_KEY, 32'h1234_5678);
    write_reg(REG_MAX_ENTRIES, 32'd2);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_FORWARD, 32'h0);
    add_cmd(CMD_VISIT, 32'h0BAD_F00D);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_VISIT, 32'h8000_0001, 1'b1);
    wait_idle();

    // A limit of zero keeps a single entry.
    write_reg(REG_MAX_ENTRIES, 32'd0);
    add_cmd(CMD_VISIT, 32'h0000_0001);
    add_cmd(CMD_VISIT, 32'h8000_0000);
    add_cmd(CMD_BACK, 32'h0);
    add_cmd(CMD_FORWARD, 32'h0);
    add_cmd(CMD_NONE, 32'h0);

    phase_max[0] = MAX_W'(16);
    phase_max[1] = MAX_W'(1);
    phase_max[2] = MAX_W'(31);
    phase_max[3] = MAX_W'(2);
    phase_max[4] = MAX_W'(0);
    phase_max[5] = MAX_W'($urandom_range(3, 15));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle = 37;
        recv_idle = 47;
      end else if (p < 4) begin
        send_idle = 47;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      home = $urandom;
      write_reg(REG_HOME_KEY, home);
      write_reg(REG_MAX_ENTRIES, 32'(phase_max[p]));
      key_pool[0] = home;
      key_pool[1] = $urandom;
      key_pool[2] = $urandom;
      key_pool[3] = 32'h1 << $urandom_range(31);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        nav_queue.insert(nav_queue.size(), random_command());
      end
    end

    wait_idle();
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS bounded_back_forward_history");
    end else begin
      $display("FAIL bounded_back_forward_history");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bbfh_pkg.sv
hdl/bbfh_store.sv
hdl/bbfh_ctrl.sv
hdl/bounded_back_forward_history.sv
hdl/bbfh_checker.sv
tb/bounded_back_forward_history_tb.sv
